FILE: rtl/core/ultrasonic_range_speed_unit_defines.svh
// ----------------------------------------------------------------------------
// ultrasonic range/speed unit assertion macros
// shared property forms for the concurrent checks of the core
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_RANGE_SPEED_UNIT_DEFINES_SVH
`define ULTRASONIC_RANGE_SPEED_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, held off during rst
`define URSU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, held off during rst
`define URSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ursu_pkg.sv
// ----------------------------------------------------------------------------
// ursu_pkg
// types and constants of the ultrasonic range/speed unit
// ----------------------------------------------------------------------------
`default_nettype none

package ursu_pkg;

  localparam int DIST_W    = 16;               // distance and duration width
  localparam int TPS_W     = 24;               // ticks per second width
  localparam int PROD_W    = DIST_W + TPS_W;   // product / speed dividend width
  localparam int SPEED_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;
  localparam int IN_W      = 8;                // s_tdata width
  localparam int OUT_FLD_W = 3 + DIST_W + SPEED_W;
  localparam int OUT_W     = ((OUT_FLD_W + 7) / 8) * 8;

  // register indexes of the config channel
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TPC       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TPS       = 3'd4;

  // reset values of the registers
  localparam logic [7:0]       TRIG_LOW_RST  = 8'd2;
  localparam logic [7:0]       TRIG_HIGH_RST = 8'd10;
  localparam logic [15:0]      SETTLE_RST    = 16'd60000;
  localparam logic [7:0]       TPC_RST       = 8'd58;
  localparam logic [TPS_W-1:0] TPS_RST       = 24'd1000000;

  localparam logic [SPEED_W-1:0] SPEED_POS_MAX = 16'h7fff;
  localparam logic [SPEED_W-1:0] SPEED_NEG_MAX = 16'h8000;
  localparam logic [PROD_W-1:0]  Q_POS_LIMIT   = 40'd32767;
  localparam logic [PROD_W-1:0]  Q_NEG_LIMIT   = 40'd32768;

  // measurement sequence phase
  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_LOW    = 4'b0010,
    PH_HIGH   = 4'b0100,
    PH_SETTLE = 4'b1000
  } phase_t;

  // per-item control flow
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIST = 6'b000010,
    S_SEQ  = 6'b000100,
    S_MUL  = 6'b001000,
    S_DIV  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/ultrasonic_range_speed_unit.sv
// ----------------------------------------------------------------------------
// ultrasonic_range_speed_unit
// echo timing, trigger sequencing, distance and speed from echo pulses
// ----------------------------------------------------------------------------
//  channel  | direction | request moves
//  s_*      | in        | one tick: echo_level, measure_request
//  m_*      | out       | one result: trigger, busy, report, distance, speed
//  cfg_*    | in        | one register write: index, data
//
//  an item passes accept, sequence step and output load; a falling
//  echo edge with nonzero duration adds 16 steps of the bit-serial divider,
//  a report with a speed estimate adds 16 multiply steps and 40 divide steps;
//  the shared shift-subtract divider serves both the distance and the speed
//  division; reset is synchronous and clears all control and model state
//  a new request is taken while the previous result still sits in the output
//  register; the block holds in its last cycle until that register is free
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_range_speed_unit #(
  parameter int TIME_WIDTH = 32
) (
  input  wire                                clk,
  input  wire                                rst,
  // [0] echo_level, [1] measure_request, [7:2] zero
  input  wire  [ursu_pkg::IN_W-1:0]          s_tdata,
  input  wire                                s_tvalid,
  output logic                               s_tready,
  // [0] trigger_out, [1] busy_res, [2] report_valid, [18:3] distance in cm,
  // [34:19] speed_cm_per_s, [39:35] zero
  output logic [ursu_pkg::OUT_W-1:0]         m_tdata,
  output logic                               m_tvalid,
  input  wire                                m_tready,
  input  wire  [ursu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [ursu_pkg::CFG_DAT_W-1:0]     cfg_data,
  input  wire                                cfg_valid,
  output logic                               cfg_ready
);
  import ursu_pkg::*;

  localparam int TW     = TIME_WIDTH;
  localparam int CNT_W  = $clog2(PROD_W + 1);
  localparam int PAD_W  = OUT_W - OUT_FLD_W;

  localparam logic [CNT_W-1:0] DIST_LAST = CNT_W'(DIST_W - 1);
  localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(DIST_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(PROD_W - 1);

  // config registers
  logic [7:0]       trig_low;
  logic [7:0]       trig_high;
  logic [15:0]      settle;
  logic [7:0]       tpc;
  logic [TPS_W-1:0] tps;

  // model state
  logic [TW-1:0]      tick_time;
  logic               echo_last;
  logic [TW-1:0]      echo_rise_time;
  logic [DIST_W-1:0]  distance_now;
  logic [DIST_W-1:0]  distance_before;
  logic [TW-1:0]      report_time_before;
  logic               first_report;
  phase_t             phase;
  logic [15:0]        phase_count;
  logic [SPEED_W-1:0] speed_last;

  // control
  state_t     state;
  logic [CNT_W-1:0] step_cnt;
  logic       req;
  logic       trig_r, busy_r, rep_r;
  logic       out_load;

  // serial datapath
  logic [PROD_W-1:0] work;     // dividend / quotient, or product accumulator
  logic [TW-1:0]     rem;
  logic [TW-1:0]     dvs;
  logic [DIST_W-1:0] mplr;
  logic              neg;

  // ---------------------------------------------------------------- edge path
  logic              echo_in;
  logic [TW-1:0]     dur_full;
  logic [DIST_W-1:0] dur;
  logic              start_dist;

  assign echo_in  = s_tdata[0];
  assign dur_full = tick_time - echo_rise_time;
  assign dur      = (|dur_full[TW-1:DIST_W]) ? {DIST_W{1'b1}} : dur_full[DIST_W-1:0];
  assign start_dist = (echo_in != echo_last) && !echo_in && (dur != '0);

  // ---------------------------------------------------------- sequence step
  phase_t      ph_a, ph_b, ph_n;
  logic [15:0] cnt_a, cnt_b, cnt_n;
  logic        busy_n, trig_n, rep_n;
  logic [TW-1:0]     dt;
  logic              dd_neg;
  logic [DIST_W-1:0] dd;

  always_comb begin
    ph_a  = phase;
    cnt_a = phase_count;
    if (phase == PH_IDLE && req) begin
      ph_a  = PH_LOW;
      cnt_a = {8'd0, trig_low};
    end
    // skip phases of zero length
    ph_b  = ph_a;
    cnt_b = cnt_a;
    if (ph_b == PH_LOW && cnt_b == '0) begin
      ph_b  = PH_HIGH;
      cnt_b = {8'd0, trig_high};
    end
    if (ph_b == PH_HIGH && cnt_b == '0) begin
      ph_b  = PH_SETTLE;
      cnt_b = settle;
    end
    busy_n = (ph_a != PH_IDLE);
    ph_n   = ph_b;
    cnt_n  = cnt_b;
    if (ph_b != PH_IDLE && !(ph_b == PH_SETTLE && cnt_b == '0)) begin
      cnt_n = cnt_b - 16'd1;
    end
    trig_n = (ph_b == PH_HIGH);
    rep_n  = (ph_b == PH_SETTLE) && (cnt_n == '0);
    if (rep_n) begin
      ph_n  = PH_IDLE;
      cnt_n = '0;
    end
  end

  assign dt     = tick_time - report_time_before;
  assign dd_neg = distance_now < distance_before;
  assign dd     = dd_neg ? (distance_before - distance_now) : (distance_now - distance_before);

  // --------------------------------------------- shift-subtract divider step
  logic [TW:0]       trial;
  logic              ge;
  logic [TW-1:0]     rem_next;
  logic [PROD_W-1:0] work_next;

  assign trial     = {rem, work[PROD_W-1]};
  assign ge        = trial >= {1'b0, dvs};
  assign rem_next  = ge ? TW'(trial - {1'b0, dvs}) : trial[TW-1:0];
  assign work_next = {work[PROD_W-2:0], ge};

  // shift-add multiplier step, multiplier msb first
  logic [PROD_W-1:0] acc_next;
  assign acc_next = {work[PROD_W-2:0], 1'b0} +
                    (mplr[DIST_W-1] ? {{DIST_W{1'b0}}, tps} : '0);

  // saturated signed speed from the final quotient
  logic [SPEED_W-1:0] speed_sat;
  always_comb begin
    if (neg) begin
      speed_sat = (work_next > Q_NEG_LIMIT) ? SPEED_NEG_MAX
                                            : (~work_next[SPEED_W-1:0] + 16'd1);
    end else begin
      speed_sat = (work_next > Q_POS_LIMIT) ? SPEED_POS_MAX : work_next[SPEED_W-1:0];
    end
  end

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  // finished tick moves into the output register
  assign out_load  = (state == S_DONE) && (!m_tvalid || m_tready);

  // --------------------------------------------------------- config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      trig_low  <= TRIG_LOW_RST;
      trig_high <= TRIG_HIGH_RST;
      settle    <= SETTLE_RST;
      tpc       <= TPC_RST;
      tps       <= TPS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TRIG_LOW:  trig_low  <= cfg_data[7:0];
        REG_TRIG_HIGH: trig_high <= cfg_data[7:0];
        REG_SETTLE:    settle    <= cfg_data[15:0];
        REG_TPC:       tpc       <= cfg_data[7:0];
        REG_TPS:       tps       <= cfg_data[TPS_W-1:0];
        default:       ;
      endcase
    end
  end

  // ---------------------------------------------------- control and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      step_cnt           <= '0;
      req                <= 1'b0;
      trig_r             <= 1'b0;
      busy_r             <= 1'b0;
      rep_r              <= 1'b0;
      tick_time          <= '0;
      echo_last          <= 1'b0;
      echo_rise_time     <= '0;
      distance_now       <= '0;
      distance_before    <= '0;
      report_time_before <= '0;
      first_report       <= 1'b1;
      phase              <= PH_IDLE;
      phase_count        <= '0;
      speed_last         <= '0;
      m_tvalid           <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            req      <= s_tdata[1];
            step_cnt <= '0;
            if (echo_in != echo_last) begin
              echo_last <= echo_in;
              if (echo_in) begin
                echo_rise_time <= tick_time;
              end
            end
            state <= start_dist ? S_DIST : S_SEQ;
          end
        end
        S_DIST: begin
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == DIST_LAST) begin
            distance_now <= work_next[DIST_W-1:0];
            state        <= S_SEQ;
          end
        end
        S_SEQ: begin
          phase       <= ph_n;
          phase_count <= cnt_n;
          trig_r      <= trig_n;
          busy_r      <= busy_n;
          rep_r       <= rep_n;
          step_cnt    <= '0;
          if (rep_n) begin
            first_report       <= 1'b0;
            report_time_before <= tick_time;
            distance_before    <= distance_now;
            if (first_report || dt == '0) begin
              speed_last <= '0;
              state      <= S_DONE;
            end else begin
              state <= S_MUL;
            end
          end else begin
            state <= S_DONE;
          end
        end
        S_MUL: begin
          if (step_cnt == MUL_LAST) begin
            step_cnt <= '0;
            state    <= S_DIV;
          end else begin
            step_cnt <= step_cnt + 1'b1;
          end
        end
        S_DIV: begin
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == DIV_LAST) begin
            speed_last <= speed_sat;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            tick_time <= tick_time + 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ------------------------------------------------------ serial datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        work <= {dur, {(PROD_W - DIST_W){1'b0}}};
        rem  <= '0;
        dvs  <= TW'((tpc == '0) ? 8'd1 : tpc);
      end
      S_DIST, S_DIV: begin
        work <= work_next;
        rem  <= rem_next;
      end
      S_SEQ: begin
        work <= '0;
        rem  <= '0;
        dvs  <= dt;
        mplr <= dd;
        neg  <= dd_neg;
      end
      S_MUL: begin
        work <= acc_next;
        mplr <= {mplr[DIST_W-2:0], 1'b0};
      end
      S_DONE: begin
        if (out_load) begin
          m_tdata <= {{PAD_W{1'b0}}, speed_last, distance_now, rep_r, busy_r, trig_r};
        end
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------------ assertions
  `include "ultrasonic_range_speed_unit_defines.svh"

  // trigger or report flag in an output request
  logic out_flag;
  assign out_flag = m_tvalid && (m_tdata[2] || m_tdata[0]);

  `URSU_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, state != S_IDLE, "tick not started")
  `URSU_ASSERT_NEXT(a_out_load, out_load, m_tvalid && state == S_IDLE, "result not loaded")
  `URSU_ASSERT_NOW(a_flag_busy, out_flag, m_tdata[1], "trigger or report while idle")

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for ultrasonic_range_speed_unit: every accepted tick
// runs through a bit-accurate model of echo timing, the trigger sequence and
// the speed estimate; every output request is compared with the oldest
// expected reading while both stream sides idle at random
// ----------------------------------------------------------------------------
import ursu_pkg::*;

class ranging_scoreboard;
  typedef struct {
    bit          trig;
    bit          busy;
    bit          report;
    logic [15:0] range_cm;
    logic [15:0] speed;
  } reading_t;

  reading_t expected_readings[$];

  // register copies
  logic [7:0]       low_ticks, high_ticks, tpc;
  logic [15:0]      settle;
  logic [TPS_W-1:0] tps;

  // model state
  logic [31:0] tick_now, echo_rise_at, last_report_at;
  bit          echo_prev, awaiting_first;
  logic [15:0] dist_now, dist_prev, phase_left, speed_held;
  phase_t      seq_phase;

  int errors, ticks, reports, clipped, writes;

  function new();
    low_ticks      = TRIG_LOW_RST;
    high_ticks     = TRIG_HIGH_RST;
    settle         = SETTLE_RST;
    tpc            = TPC_RST;
    tps            = TPS_RST;
    tick_now       = '0;
    echo_rise_at   = '0;
    last_report_at = '0;
    echo_prev      = 1'b0;
    awaiting_first = 1'b1;
    dist_now       = '0;
    dist_prev      = '0;
    phase_left     = '0;
    speed_held     = '0;
    seq_phase      = PH_IDLE;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    case (idx)
      REG_TRIG_LOW:  low_ticks  = val[7:0];
      REG_TRIG_HIGH: high_ticks = val[7:0];
      REG_SETTLE:    settle     = val[15:0];
      REG_TPC:       tpc        = val[7:0];
      REG_TPS:       tps        = val[TPS_W-1:0];
      default: ;
    endcase
    writes++;
  endfunction

  function int pending();
    return expected_readings.size();
  endfunction

  function bit seq_idle();
    return seq_phase == PH_IDLE;
  endfunction

  function void enter_phase(phase_t ph);
    seq_phase = ph;
    case (ph)
      PH_LOW:    phase_left = 16'(low_ticks);
      PH_HIGH:   phase_left = 16'(high_ticks);
      PH_SETTLE: phase_left = settle;
      default:   phase_left = '0;
    endcase
  endfunction

  // speed of a report, signed 16 bit, clipped; also rolls the report history
  function logic [15:0] report_speed(logic [31:0] now);
    logic [31:0] dt;
    logic [15:0] dd;
    logic [63:0] q;
    logic [15:0] sp;
    bit          neg;
    sp = '0;
    if (awaiting_first) begin
      awaiting_first = 1'b0;
    end else begin
      dt = now - last_report_at;
      if (dt != 0) begin
        neg = dist_now < dist_prev;
        dd  = neg ? dist_prev - dist_now : dist_now - dist_prev;
        q   = (64'(dd) * 64'(tps)) / 64'(dt);
        if (neg) begin
          if (q > 64'(Q_NEG_LIMIT)) begin
            sp = SPEED_NEG_MAX;
            clipped++;
          end else begin
            sp = 16'(-q);
          end
        end else begin
          if (q > 64'(Q_POS_LIMIT)) begin
            sp = SPEED_POS_MAX;
            clipped++;
          end else begin
            sp = 16'(q);
          end
        end
      end
    end
    last_report_at = now;
    dist_prev      = dist_now;
    return sp;
  endfunction

  // one accepted tick: advance the model and queue the reading it must give
  function void note_tick(bit echo, bit req);
    reading_t    r;
    logic [31:0] now, dur;
    now      = tick_now;
    r.trig   = 1'b0;
    r.busy   = 1'b0;
    r.report = 1'b0;
    // echo edges are timed whether or not a measurement runs
    if (echo != echo_prev) begin
      if (echo) begin
        echo_rise_at = now;
      end else begin
        dur = now - echo_rise_at;
        if (dur > 32'd65535) dur = 32'd65535;
        if (dur != 0) dist_now = 16'(dur / ((tpc == 0) ? 32'd1 : 32'(tpc)));
      end
      echo_prev = echo;
    end
    if (seq_phase == PH_IDLE && req) enter_phase(PH_LOW);
    if (seq_phase != PH_IDLE) begin
      r.busy = 1'b1;
      // empty phases take no tick
      while (seq_phase != PH_SETTLE && phase_left == 0)
        enter_phase((seq_phase == PH_LOW) ? PH_HIGH : PH_SETTLE);
      if (seq_phase != PH_SETTLE || phase_left != 0) phase_left--;
      r.trig = (seq_phase == PH_HIGH);
      if (seq_phase == PH_SETTLE && phase_left == 0) begin
        r.report   = 1'b1;
        speed_held = report_speed(now);
        reports++;
        enter_phase(PH_IDLE);
      end
    end
    r.range_cm = dist_now;
    r.speed    = speed_held;
    tick_now   = now + 32'd1;
    ticks++;
    expected_readings.push_back(r);
  endfunction

  function void compare(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      errors++;
    end
  endfunction

  function void check_result(logic [OUT_W-1:0] word);
    reading_t e;
    if (expected_readings.size() == 0) begin
      $error("result with no reading expected: %h", word);
      errors++;
      return;
    end
    e = expected_readings.pop_front();
    compare("trigger_out", 16'(e.trig), 16'(word[0]));
    compare("busy_res", 16'(e.busy), 16'(word[1]));
    compare("report_valid", 16'(e.report), 16'(word[2]));
    compare("range_cm", e.range_cm, word[18:3]);
    compare("speed_cm_per_s", e.speed, word[34:19]);
    compare("tdata padding", 16'd0, 16'(word[OUT_W-1:35]));
  endfunction
endclass

module tb;
  localparam int STALL_LIMIT = 5000;   // cycles with no request moving on any channel

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic [IN_W-1:0]      s_tdata   = '0;
  logic                 s_tvalid  = 1'b0;
  wire                  s_tready;
  wire  [OUT_W-1:0]     m_tdata;
  wire                  m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;
  logic                 cfg_valid = 1'b0;
  wire                  cfg_ready;

  ranging_scoreboard sb = new();

  int src_idle_pct  = 0;   // sender idle chance per cycle, percent
  int snk_idle_pct  = 0;   // receiver stall chance per cycle, percent
  int quiet_cycles  = 0;
  int echo_run_left = 0;   // ticks left before the random echo level flips
  bit echo_lvl      = 1'b0;

  ultrasonic_range_speed_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
  );

  always #10 clk = ~clk;

  // receiver: stalls at random, decided at the falling edge
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // every result request is checked at the edge that accepts it
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // watchdog: ends a run that stops moving
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("ultrasonic_range_speed_unit test failed");
      $finish;
    end
  end

  // one tick request; entered and left at a falling edge, valid stays high
  // across back-to-back ticks
  task automatic send_tick(input bit echo, input bit req);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tdata  <= {{(IN_W-2){1'b0}}, req, echo};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.note_tick(echo, req);
    @(negedge clk);
  endtask

  task automatic run_ticks(input int n, input bit echo, input bit req);
    repeat (n) send_tick(echo, req);
  endtask

  // sender holds off until every expected reading has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // writes all five registers once the stream is quiet
  task automatic configure(input logic [CFG_DAT_W-1:0] lo, hi, st, tpc, tps);
    logic [CFG_DAT_W-1:0] vals [5];
    logic [CFG_IDX_W-1:0] regs [5];
    vals = '{lo, hi, st, tpc, tps};
    regs = '{REG_TRIG_LOW, REG_TRIG_HIGH, REG_SETTLE, REG_TPC, REG_TPS};
    drain_results();
    for (int i = 0; i < 5; i++) begin
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(regs[i], vals[i]);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // random ticks: echo pulses of random length, requests mostly when the
  // sequence is idle so measurements run back to back, rare full drains
  task automatic random_ticks(input int n);
    bit req;
    for (int i = 0; i < n; i++) begin
      if (echo_run_left == 0) begin
        echo_lvl      = ~echo_lvl;
        echo_run_left = ($urandom_range(9) == 0) ? $urandom_range(61, 400)
                                                 : $urandom_range(1, 60);
      end
      echo_run_left--;
      if (sb.seq_idle()) req = ($urandom_range(99) < 70);
      else req = 1'($urandom_range(1));
      if ($urandom_range(199) == 0) drain_results();
      send_tick(echo_lvl, req);
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: short echo pulses, no request, distance truncates to 0
    run_ticks(3, 1'b1, 1'b0);
    run_ticks(2, 1'b0, 1'b0);

    // all-zero registers: empty phases, report on the request tick,
    // divisor of zero counts as one, zero tick rate gives zero speed
    configure(24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
    run_ticks(2, 1'b1, 1'b0);
    run_ticks(2, 1'b0, 1'b1);

    // shortest real sequence at the top tick rate: first report, then speed
    // clipped high and clipped low; requests while busy are dropped
    configure(24'd1, 24'd2, 24'd1, 24'd1, 24'hFFFFFF);
    run_ticks(2, 1'b1, 1'b0);
    run_ticks(4, 1'b0, 1'b1);
    run_ticks(8, 1'b1, 1'b0);
    run_ticks(4, 1'b0, 1'b1);
    run_ticks(1, 1'b1, 1'b0);
    run_ticks(4, 1'b0, 1'b1);

    // longest trigger phases, echo held high through most of the sequence,
    // requests while busy are dropped, the echo falls during the settle wait
    configure(24'd255, 24'd255, 24'd40, 24'd1, 24'd1000000);
    run_ticks(540, 1'b1, 1'b1);
    while (!sb.seq_idle()) send_tick(1'b0, 1'b0);

    // random part: three idle patterns, fresh settings every chunk, written
    // with junk above the width of every register but the tick rate
    for (int mode = 0; mode < 3; mode++) begin
      src_idle_pct = (mode == 0) ? 32 : (mode == 1) ? 75 : 0;
      snk_idle_pct = (mode == 0) ? 75 : (mode == 1) ? 32 : 0;
      for (int k = 0; k < 4; k++) begin
        configure(24'($urandom_range(0, 4) | ($urandom & 32'hFFFF00)),
                  24'((($urandom_range(9) == 0) ? 32'd0 : $urandom_range(1, 5))
                      | ($urandom & 32'hFFFF00)),
                  24'((($urandom_range(9) == 0) ? 32'd0 : $urandom_range(1, 16))
                      | ($urandom & 32'hFF0000)),
                  24'((($urandom_range(3) == 0) ? $urandom_range(1, 255)
                                                : $urandom_range(1, 6))
                      | ($urandom & 32'hFFFF00)),
                  ($urandom_range(3) == 0) ? 24'd1 :
                  ($urandom_range(2) == 0) ? 24'hFFFFFF :
                  ($urandom_range(1) == 0) ? 24'd1000000 :
                                             24'($urandom_range(1, 24'hFFFFFF)));
        random_ticks(55);
      end
    end

    drain_results();
    repeat (100) @(posedge clk);
    $display("covered %0d ticks, %0d range reports (%0d with clipped speed),",
             sb.ticks, sb.reports, sb.clipped);
    $display("  %0d register writes under three idle patterns", sb.writes);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ultrasonic_range_speed_unit test passed");
    end else begin
      $display("ultrasonic_range_speed_unit test failed");
    end
    $finish;
  end
endmodule

FILE: ultrasonic_range_speed_unit.f
+incdir+rtl/core
rtl/core/ursu_pkg.sv
rtl/core/ultrasonic_range_speed_unit.sv
tb/tb.sv
